@@ rtl/core/blr_pkg.sv @@
// Shared types and constants of the midpoint line rasteriser.
// No dependencies; imported by blr_step and bresenham_line_rasterizer_core.
`default_nettype none

package blr_pkg;

  // Default coordinate width (range 4..16).
  localparam int unsigned COORD_BITS_DEF = 10;

  // Extra bits that the decision term carries above the coordinate width.
  localparam int unsigned ERR_EXTRA = 4;

  // Command carried in the input beat's tuser.
  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } blr_cmd_t;

  // Mode and direction flags of the line being traced.
  typedef struct packed {
    logic steep;
    logic col_back;
    logic row_back;
    logic busy;
  } blr_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/blr_step.sv @@
// One step of the line rasteriser: set-up on start, one pixel advance on next.
// Purely combinational; depends on blr_pkg.
`default_nettype none

module blr_step #(
  parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  wire blr_pkg::blr_cmd_t           cmd,
  input  wire logic [COORD_BITS-1:0]       start_x,
  input  wire logic [COORD_BITS-1:0]       start_y,
  input  wire logic [COORD_BITS-1:0]       stop_x,
  input  wire logic [COORD_BITS-1:0]       stop_y,
  input  wire logic [COORD_BITS-1:0]       cur_col,
  input  wire logic [COORD_BITS-1:0]       cur_row,
  input  wire logic [COORD_BITS-1:0]       goal_col,
  input  wire logic [COORD_BITS-1:0]       goal_row,
  input  wire logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] err,
  input  wire logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] sinc,
  input  wire logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] dinc,
  input  wire blr_pkg::blr_flags_t         flags,
  output logic [COORD_BITS-1:0]            cur_col_nxt,
  output logic [COORD_BITS-1:0]            cur_row_nxt,
  output logic [COORD_BITS-1:0]            goal_col_nxt,
  output logic [COORD_BITS-1:0]            goal_row_nxt,
  output logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] err_nxt,
  output logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] sinc_nxt,
  output logic signed [COORD_BITS+blr_pkg::ERR_EXTRA-1:0] dinc_nxt,
  output blr_pkg::blr_flags_t              flags_nxt,
  output logic                             emit,
  output logic                             last
);
  import blr_pkg::*;

  localparam int unsigned EW = COORD_BITS + ERR_EXTRA;

  logic [COORD_BITS-1:0] dx, dy;
  logic signed [EW-1:0]  dx_e, dy_e;
  logic                  steep_s;
  logic [COORD_BITS-1:0] col_mv, row_mv;
  logic                  err_pos, err_neg;

  assign dx   = (stop_x >= start_x) ? stop_x - start_x : start_x - stop_x;
  assign dy   = (stop_y >= start_y) ? stop_y - start_y : start_y - stop_y;
  assign dx_e = signed'(EW'(dx));
  assign dy_e = signed'(EW'(dy));
  assign steep_s = dy > dx;

  assign col_mv  = flags.col_back ? cur_col - 1'b1 : cur_col + 1'b1;
  assign row_mv  = flags.row_back ? cur_row - 1'b1 : cur_row + 1'b1;
  assign err_neg = err[EW-1];
  assign err_pos = !err[EW-1] && (err != '0);

  always_comb begin
    cur_col_nxt  = cur_col;
    cur_row_nxt  = cur_row;
    goal_col_nxt = goal_col;
    goal_row_nxt = goal_row;
    err_nxt      = err;
    sinc_nxt     = sinc;
    dinc_nxt     = dinc;
    flags_nxt    = flags;
    emit         = 1'b0;
    last         = 1'b0;
    case (cmd)
      CMD_START: begin
        cur_col_nxt        = start_x;
        cur_row_nxt        = start_y;
        goal_col_nxt       = stop_x;
        goal_row_nxt       = stop_y;
        flags_nxt.col_back = stop_x < start_x;
        flags_nxt.row_back = stop_y < start_y;
        flags_nxt.steep    = steep_s;
        if (steep_s) begin
          err_nxt  = (dx_e <<< 1) - dy_e;
          sinc_nxt = dx_e <<< 1;
        end else begin
          err_nxt  = dx_e - (dy_e <<< 1);
          sinc_nxt = -(dy_e <<< 1);
        end
        dinc_nxt       = (dx_e - dy_e) <<< 1;
        last           = steep_s ? (start_y == stop_y) : (start_x == stop_x);
        emit           = 1'b1;
        flags_nxt.busy = !last;
      end
      CMD_NEXT: begin
        if (flags.busy) begin
          if (!flags.steep) begin
            cur_col_nxt = col_mv;
            if (err_pos) begin
              err_nxt = err + sinc;
            end else begin
              cur_row_nxt = row_mv;
              err_nxt     = err + dinc;
            end
            last = col_mv == goal_col;
          end else begin
            cur_row_nxt = row_mv;
            if (err_neg) begin
              err_nxt = err + sinc;
            end else begin
              cur_col_nxt = col_mv;
              err_nxt     = err + dinc;
            end
            last = row_mv == goal_row;
          end
          emit           = 1'b1;
          flags_nxt.busy = !last;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bresenham_line_rasterizer_core.sv @@
// Midpoint line rasteriser, top level: input beat register, step logic, result register.
// An input beat passes through the input register, then the result register, on its way to the pixel beat.
// Throughput: one command beat per cycle while out_tready is high; each next command costs one add and compare.
// Reset (rst_n low, synchronous): both beat registers empty, line state cleared, idle.
// Depends on blr_pkg and blr_step.
`default_nettype none

module bresenham_line_rasterizer_core #(
  parameter int unsigned COORD_BITS = blr_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // command beats
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // tdata, lowest bit up: start_x, start_y, stop_x, stop_y, zero fill to bytes
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]    in_tdata,
  // tuser: command (0 start, 1 next)
  input  wire logic                                 in_tuser,
  // pixel beats
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // tdata, lowest bit up: pixel_x, pixel_y, zero fill to bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]         out_tdata,
  // tlast: pixel is the line's endpoint
  output logic                                      out_tlast
);
  import blr_pkg::*;

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned EW    = CB + ERR_EXTRA;
  localparam int unsigned OUT_W = ((2*CB+7)/8)*8;

  // Input beat register: parts the input handshake from the result side.
  logic                  in_valid_r;
  blr_cmd_t              in_cmd_r;
  logic [4*CB-1:0]       in_pts_r;

  // Line state.
  logic [CB-1:0]         cur_col_r, cur_row_r, goal_col_r, goal_row_r;
  logic signed [EW-1:0]  err_r, sinc_r, dinc_r;
  blr_flags_t            flags_r;

  logic [CB-1:0]         cur_col_nxt, cur_row_nxt, goal_col_nxt, goal_row_nxt;
  logic signed [EW-1:0]  err_nxt, sinc_nxt, dinc_nxt;
  blr_flags_t            flags_nxt;
  logic                  emit, last;

  // Result register.
  logic                  out_valid_r;
  logic [CB-1:0]         pix_x_r, pix_y_r;
  logic                  last_r;

  logic                  advance;
  logic                  in_acc;

  // Process the held command once the result register is free or draining.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  // Payload: hold while waiting, load on every accepted beat.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_cmd_r <= blr_cmd_t'(in_tuser);
      in_pts_r <= in_tdata[4*CB-1:0];
    end
  end

  blr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cmd          (in_cmd_r),
    .start_x      (in_pts_r[CB-1:0]),
    .start_y      (in_pts_r[2*CB-1:CB]),
    .stop_x       (in_pts_r[3*CB-1:2*CB]),
    .stop_y       (in_pts_r[4*CB-1:3*CB]),
    .cur_col      (cur_col_r),
    .cur_row      (cur_row_r),
    .goal_col     (goal_col_r),
    .goal_row     (goal_row_r),
    .err          (err_r),
    .sinc         (sinc_r),
    .dinc         (dinc_r),
    .flags        (flags_r),
    .cur_col_nxt  (cur_col_nxt),
    .cur_row_nxt  (cur_row_nxt),
    .goal_col_nxt (goal_col_nxt),
    .goal_row_nxt (goal_row_nxt),
    .err_nxt      (err_nxt),
    .sinc_nxt     (sinc_nxt),
    .dinc_nxt     (dinc_nxt),
    .flags_nxt    (flags_nxt),
    .emit         (emit),
    .last         (last)
  );

  // Line state advances with each processed command; next-while-idle leaves it as is.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      goal_col_r <= '0;
      goal_row_r <= '0;
      err_r      <= '0;
      sinc_r     <= '0;
      dinc_r     <= '0;
      flags_r    <= '0;
    end else if (advance) begin
      cur_col_r  <= cur_col_nxt;
      cur_row_r  <= cur_row_nxt;
      goal_col_r <= goal_col_nxt;
      goal_row_r <= goal_row_nxt;
      err_r      <= err_nxt;
      sinc_r     <= sinc_nxt;
      dinc_r     <= dinc_nxt;
      flags_r    <= flags_nxt;
    end
  end

  // Result beat: fill when a processed command emits, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // The emitted pixel is the position after the step.
  always_ff @(posedge clk) begin
    if (advance && emit) begin
      pix_x_r <= cur_col_nxt;
      pix_y_r <= cur_row_nxt;
      last_r  <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({pix_y_r, pix_x_r});
  assign out_tlast  = last_r;

endmodule

`default_nettype wire
